// ===== sv/fixed_partition_fit_allocator_defines.svh =====
// Assertion macros shared by the partition allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// ===== sv/fpfa_pkg.sv =====
// Types and constants of the partition allocator.
// No dependencies; used by fpfa_cell and fixed_partition_fit_allocator.
`timescale 1ns / 1ps

package fpfa_pkg;

    localparam int SIZE_W = 16;
    localparam int NUM_W  = 5;
    localparam int REQ_W  = 16;

    // Transaction kinds on the input channel.
    typedef enum logic [1:0] {
        KIND_CLEAR    = 2'd0,
        KIND_LOAD     = 2'd1,
        KIND_FREE_ALL = 2'd2,
        KIND_REQUEST  = 2'd3
    } kind_t;

    // Fit policy codes; the unused code behaves as first fit.
    typedef enum logic [1:0] {
        POLICY_FIRST = 2'd0,
        POLICY_BEST  = 2'd1,
        POLICY_WORST = 2'd2
    } policy_t;

    // Broadcast control from the controller to every cell.
    typedef struct packed {
        logic              clear_en;
        logic              load_en;
        logic              free_all_en;
        logic              commit_en;
        policy_t           policy;
        logic [SIZE_W-1:0] data;
    } cell_ctrl_t;

    // Best candidate found so far, handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] size;
    } cand_t;

endpackage

// ===== sv/fixed_partition_fit_allocator.sv =====
// Top level of the partition allocator: controller, output register and the cell chain.
// Depends on fpfa_pkg, fpfa_cell and the defines header.
//
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+-----------------------------------------------
// in      | input     | in_valid / in_ready   | kind, size_value
// out     | output    | out_valid / out_ready | granted, partition_number, partition_size,
//         |           |                       | request_number
// cfg     | input     | cfg_valid / cfg_ready | fit_policy
//
// Clear, load and free-all transactions are handled without leaving the idle state.
// A request starts a scan, passes the token through the cell chain (each cell weighs
// its partition against the candidate), then captures and commits the result.
// Reset is asynchronous and active low and empties the table; no clearing pass is needed.
// A result waiting in the output register does not block clear, load or free-all;
// a finished request waits in its commit cycle until the output register is free.
`timescale 1ns / 1ps
`include "fixed_partition_fit_allocator_defines.svh"

module fixed_partition_fit_allocator #(
    parameter int MAX_PARTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [fpfa_pkg::SIZE_W-1:0]   size_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          granted,
    output logic [fpfa_pkg::NUM_W-1:0]    partition_number,
    output logic [fpfa_pkg::SIZE_W-1:0]   partition_size,
    output logic [fpfa_pkg::REQ_W-1:0]    request_number,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    fit_policy
);

    localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t                       state_reg,       state_next;
    fpfa_pkg::policy_t            policy_reg;
    logic                         start_reg,       start_next;
    logic                         clear_reg,       clear_next;
    logic                         load_reg,        load_next;
    logic                         free_all_reg,    free_all_next;
    logic [fpfa_pkg::SIZE_W-1:0]  data_reg,        data_next;
    logic [fpfa_pkg::REQ_W-1:0]   req_count_reg,   req_count_next;
    fpfa_pkg::cand_t              hold_cand_reg,   hold_cand_next;
    logic [IDX_W-1:0]             hold_idx_reg,    hold_idx_next;
    logic                         out_valid_reg,   out_valid_next;
    logic                         granted_reg,     granted_next;
    logic [fpfa_pkg::NUM_W-1:0]   part_num_reg,    part_num_next;
    logic [fpfa_pkg::SIZE_W-1:0]  part_size_reg,   part_size_next;
    logic [fpfa_pkg::REQ_W-1:0]   req_num_reg,     req_num_next;

    logic                         in_fire;
    logic                         commit;
    logic [CNT_W-1:0]             number_wide;
    fpfa_pkg::cell_ctrl_t         ctrl;
    fpfa_pkg::kind_t              kind_in;

    logic                         tok_chain  [0:MAX_PARTS];
    fpfa_pkg::cand_t              cand_chain [0:MAX_PARTS];
    logic [IDX_W-1:0]             idx_chain  [0:MAX_PARTS];
    logic                         loaded_chain [0:MAX_PARTS];

    assign kind_in   = fpfa_pkg::kind_t'(kind);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // The held result is committed once the output register can take it.
    assign commit      = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);
    assign number_wide = CNT_W'(hold_idx_reg) + CNT_W'(1);

    // Fit policy register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= fpfa_pkg::POLICY_FIRST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            policy_reg <= fpfa_pkg::policy_t'(fit_policy);
        end
    end

    // Controller next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        clear_next     = 1'b0;
        load_next      = 1'b0;
        free_all_next  = 1'b0;
        data_next      = data_reg;
        req_count_next = req_count_reg;
        hold_cand_next = hold_cand_reg;
        hold_idx_next  = hold_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        granted_next   = granted_reg;
        part_num_next  = part_num_reg;
        part_size_next = part_size_reg;
        req_num_next   = req_num_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    data_next = size_value;
                    case (kind_in)
                        fpfa_pkg::KIND_CLEAR:
                        begin
                            clear_next     = 1'b1;
                            req_count_next = '0;
                        end
                        fpfa_pkg::KIND_LOAD:
                        begin
                            load_next = 1'b1;
                        end
                        fpfa_pkg::KIND_FREE_ALL:
                        begin
                            free_all_next  = 1'b1;
                            req_count_next = '0;
                        end
                        fpfa_pkg::KIND_REQUEST:
                        begin
                            start_next = 1'b1;
                            state_next = ST_SCAN;
                            if (req_count_reg != {fpfa_pkg::REQ_W{1'b1}})
                            begin
                                req_count_next = req_count_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            start_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (tok_chain[MAX_PARTS])
                begin
                    hold_cand_next = cand_chain[MAX_PARTS];
                    hold_idx_next  = idx_chain[MAX_PARTS];
                    state_next     = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = hold_cand_reg.valid;
                    part_num_next  = hold_cand_reg.valid ?
                                     fpfa_pkg::NUM_W'(number_wide) : '0;
                    part_size_next = hold_cand_reg.valid ? hold_cand_reg.size : '0;
                    req_num_next   = req_count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            clear_reg     <= 1'b0;
            load_reg      <= 1'b0;
            free_all_reg  <= 1'b0;
            data_reg      <= '0;
            req_count_reg <= '0;
            hold_cand_reg <= '0;
            hold_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            granted_reg   <= 1'b0;
            part_num_reg  <= '0;
            part_size_reg <= '0;
            req_num_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            clear_reg     <= clear_next;
            load_reg      <= load_next;
            free_all_reg  <= free_all_next;
            data_reg      <= data_next;
            req_count_reg <= req_count_next;
            hold_cand_reg <= hold_cand_next;
            hold_idx_reg  <= hold_idx_next;
            out_valid_reg <= out_valid_next;
            granted_reg   <= granted_next;
            part_num_reg  <= part_num_next;
            part_size_reg <= part_size_next;
            req_num_reg   <= req_num_next;
        end
    end

    // Control broadcast to all cells.
    always_comb
    begin
        ctrl.clear_en    = clear_reg;
        ctrl.load_en     = load_reg;
        ctrl.free_all_en = free_all_reg;
        ctrl.commit_en   = commit && hold_cand_reg.valid;
        ctrl.policy      = policy_reg;
        ctrl.data        = data_reg;
    end

    // Head of the chain: the scan token enters with no candidate.
    assign tok_chain[0]    = start_reg;
    assign cand_chain[0]   = '0;
    assign idx_chain[0]    = '0;
    assign loaded_chain[0] = 1'b1;

    // Row of partition cells.
    for (genvar g = 0; g < MAX_PARTS; g++)
    begin : g_cell
        fpfa_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .grant_idx   (hold_idx_reg),
            .prev_loaded (loaded_chain[g]),
            .loaded      (loaded_chain[g+1]),
            .tok_in      (tok_chain[g]),
            .cand_in     (cand_chain[g]),
            .idx_in      (idx_chain[g]),
            .tok_out     (tok_chain[g+1]),
            .cand_out    (cand_chain[g+1]),
            .idx_out     (idx_chain[g+1])
        );
    end

    assign out_valid        = out_valid_reg;
    assign granted          = granted_reg;
    assign partition_number = part_num_reg;
    assign partition_size   = part_size_reg;
    assign request_number   = req_num_reg;

    // The token leaves the chain only while a request scan is under way.
    `FPFA_ASSERT_IMPLY(a_tail_in_scan, clk, rst_n, tok_chain[MAX_PARTS], state_reg == ST_SCAN)
    // A refused request reports neither a partition nor a size.
    `FPFA_ASSERT_IMPLY(a_refused_empty, clk, rst_n, out_valid_reg && !granted_reg,
        (part_num_reg == '0) && (part_size_reg == '0))
    // Every delivered result carries a nonzero request ordinal.
    `FPFA_ASSERT_NEXT(a_req_num_nonzero, clk, rst_n, commit, req_num_reg != '0)

endmodule

// ===== sv/fpfa_cell.sv =====
// One partition slot of the allocator chain: holds size, loaded and free marks,
// and refines the travelling candidate. Depends on fpfa_pkg and the defines header.
`timescale 1ns / 1ps
`include "fixed_partition_fit_allocator_defines.svh"

module fpfa_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpfa_pkg::cell_ctrl_t   ctrl,
    input  logic [IDX_W-1:0]       grant_idx,
    input  logic                   prev_loaded,
    output logic                   loaded,
    input  logic                   tok_in,
    input  fpfa_pkg::cand_t        cand_in,
    input  logic [IDX_W-1:0]       idx_in,
    output logic                   tok_out,
    output fpfa_pkg::cand_t        cand_out,
    output logic [IDX_W-1:0]       idx_out
);

    logic                        loaded_reg;
    logic                        free_reg;
    logic [fpfa_pkg::SIZE_W-1:0] size_reg;
    logic                        tok_reg;
    fpfa_pkg::cand_t             cand_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic                        fits;
    logic                        better;
    logic                        take;
    logic                        load_here;
    logic                        grant_here;

    // This slot is the next one to load when the slots before it are filled.
    assign load_here  = ctrl.load_en && !loaded_reg && prev_loaded;
    assign grant_here = ctrl.commit_en && (grant_idx == IDX_W'(CELL_IDX));

    // Compare this partition against the candidate coming from upstream.
    assign fits = loaded_reg && free_reg && (size_reg >= ctrl.data);

    always_comb
    begin
        case (ctrl.policy)
            fpfa_pkg::POLICY_BEST:  better = size_reg < cand_in.size;
            fpfa_pkg::POLICY_WORST: better = size_reg >= cand_in.size;
            default:                better = 1'b0;
        endcase
    end

    assign take = fits && (!cand_in.valid || better);

    // Marks and the scan token.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            free_reg   <= 1'b0;
            tok_reg    <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (ctrl.clear_en)
            begin
                loaded_reg <= 1'b0;
                free_reg   <= 1'b0;
            end
            else if (load_here)
            begin
                loaded_reg <= 1'b1;
                free_reg   <= 1'b1;
            end
            else if (ctrl.free_all_en && loaded_reg)
            begin
                free_reg <= 1'b1;
            end
            else if (grant_here)
            begin
                free_reg <= 1'b0;
            end
        end
    end

    // Partition size and the candidate handed downstream.
    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            size_reg <= ctrl.data;
        end
        if (take)
        begin
            cand_reg.valid <= 1'b1;
            cand_reg.size  <= size_reg;
            idx_reg        <= IDX_W'(CELL_IDX);
        end
        else
        begin
            cand_reg <= cand_in;
            idx_reg  <= idx_in;
        end
    end

    assign loaded   = loaded_reg;
    assign tok_out  = tok_reg;
    assign cand_out = cand_reg;
    assign idx_out  = idx_reg;

    // A free slot is always a loaded slot.
    `FPFA_ASSERT_IMPLY(a_free_is_loaded, clk, rst_n, free_reg, loaded_reg)
    // Loaded slots form an unbroken run from the head of the chain.
    `FPFA_ASSERT_IMPLY(a_loaded_contiguous, clk, rst_n, loaded_reg, prev_loaded)
    // A grant only ever lands on a slot that is free.
    `FPFA_ASSERT_IMPLY(a_grant_hits_free, clk, rst_n, grant_here, free_reg)

endmodule
